@@ rtl/deq_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and codes for the double-ended queue.
// No dependencies.
package deq_pkg;

    localparam int DATA_W      = 32;
    localparam int MAX_RESULTS = 16;

    localparam logic [2:0] REQ_PUSH_FRONT = 3'd0;
    localparam logic [2:0] REQ_PUSH_BACK  = 3'd1;
    localparam logic [2:0] REQ_POP_FRONT  = 3'd2;
    localparam logic [2:0] REQ_POP_BACK   = 3'd3;
    localparam logic [2:0] REQ_LIST       = 3'd4;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_UNDERFLOW = 2'd1;
    localparam logic [1:0] ST_OVERFLOW  = 2'd2;
    localparam logic [1:0] ST_EMPTY     = 2'd3;

    // Cell operations, broadcast to every cell of the chain
    localparam logic [2:0] CELL_HOLD       = 3'd0;
    localparam logic [2:0] CELL_TAKE_LOWER = 3'd1;
    localparam logic [2:0] CELL_TAKE_UPPER = 3'd2;
    localparam logic [2:0] CELL_ROTATE     = 3'd3;
    localparam logic [2:0] CELL_WRITE      = 3'd4;

    typedef struct packed {
        logic [2:0] op;
        logic       sel;
    } cell_ctrl_t;

endpackage

@@ rtl/deq_req_if.sv @@
`timescale 1ns / 1ps
// Request channel: valid/ready handshake with request code and push value.
// Depends on deq_pkg.
interface deq_req_if import deq_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [2:0]               req_type;
    logic signed [DATA_W-1:0] value;

    modport source (output valid, output req_type, output value, input ready);
    modport sink   (input valid, input req_type, input value, output ready);
endinterface

@@ rtl/deq_rsp_if.sv @@
`timescale 1ns / 1ps
// Result channel: valid/ready handshake with status, data and last flag.
// Depends on deq_pkg.
interface deq_rsp_if import deq_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [1:0]               status;
    logic signed [DATA_W-1:0] data;
    logic                     last;

    modport source (output valid, output status, output data, output last, input ready);
    modport sink   (input valid, input status, input data, input last, output ready);
endinterface

@@ rtl/deq_cell.sv @@
`timescale 1ns / 1ps
// One storage cell of the queue chain; exchanges its entry with its neighbors.
// Depends on deq_pkg.
module deq_cell import deq_pkg::*;
(
    input  logic                     clk,
    input  cell_ctrl_t               ctrl,
    input  logic signed [DATA_W-1:0] lower,
    input  logic signed [DATA_W-1:0] upper,
    input  logic signed [DATA_W-1:0] head,
    input  logic signed [DATA_W-1:0] push_value,
    output logic signed [DATA_W-1:0] entry
);

    logic signed [DATA_W-1:0] entry_reg;
    logic signed [DATA_W-1:0] entry_next;

    always_comb
    begin
        unique case (ctrl.op)
            CELL_TAKE_LOWER: entry_next = lower;
            CELL_TAKE_UPPER: entry_next = upper;
            CELL_ROTATE:     entry_next = ctrl.sel ? head : upper;
            CELL_WRITE:      entry_next = ctrl.sel ? push_value : entry_reg;
            default:         entry_next = entry_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

@@ rtl/double_ended_queue.sv @@
`timescale 1ns / 1ps
// Top level of the double-ended queue: control sequencer, cell chain, result register.
// Depends on deq_pkg, deq_req_if, deq_rsp_if, deq_cell.
//
// Entries sit in a chain of DEPTH cells with the front always in cell 0. Push front,
// push back and pop front complete in the cycle in which the request is taken. A result
// waits in an output register, and a new request is taken only once that register is
// empty or is being read in the same cycle. Pop back with N >= 2 stored entries goes
// from the request to a rotation state, in which the chain rotates to bring the back
// entry to cell 0, and then to a pop state that pops it. A list of N entries rotates
// the chain once per entry, which also restores the order. At most 16 results are sent,
// and the rest of the rotation runs without output. A stalled result receiver adds its
// stall cycles to the pop back and list sequences. Full and empty requests get a
// matching status, unknown-code requests no result. No clearing pass is needed after reset.
module double_ended_queue import deq_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  logic       clk,
    input  logic       rst_n,
    deq_req_if.sink    req,
    deq_rsp_if.source  rsp
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_ROT  = 2'd1;
    localparam logic [1:0] S_POPB = 2'd2;
    localparam logic [1:0] S_LIST = 2'd3;

    logic [1:0]       state_reg, state_next;
    logic [IDX_W-1:0] step_reg, step_next;
    logic [CNT_W-1:0] count_reg, count_next;

    logic                     out_valid_reg;
    logic [1:0]               out_status_reg;
    logic signed [DATA_W-1:0] out_data_reg;
    logic                     out_last_reg;

    logic                     load_out;
    logic [1:0]               o_status;
    logic signed [DATA_W-1:0] o_data;
    logic                     o_last;

    logic [2:0]       cell_op;
    logic             use_back_sel;
    logic [IDX_W-1:0] sel_idx;
    logic [CNT_W-1:0] count_m1;
    logic [CNT_W-1:0] count_m2;
    logic             out_free;
    logic             accept;
    logic             emit;

    logic signed [DATA_W-1:0] cell_q [DEPTH];

    assign out_free  = !out_valid_reg || rsp.ready;
    assign req.ready = (state_reg == S_IDLE) && out_free;
    assign accept    = req.valid && req.ready;
    assign count_m1  = count_reg - CNT_W'(1);
    assign count_m2  = count_reg - CNT_W'(2);
    assign sel_idx   = use_back_sel ? count_m1[IDX_W-1:0] : count_reg[IDX_W-1:0];
    assign emit      = 32'(step_reg) < MAX_RESULTS;

    always_comb
    begin
        state_next   = state_reg;
        step_next    = step_reg;
        count_next   = count_reg;
        cell_op      = CELL_HOLD;
        use_back_sel = 1'b0;
        load_out     = 1'b0;
        o_status     = ST_OK;
        o_data       = '0;
        o_last       = 1'b1;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (req.req_type)
                        REQ_PUSH_FRONT, REQ_PUSH_BACK:
                        begin
                            load_out = 1'b1;
                            if (count_reg == CNT_W'(DEPTH))
                            begin
                                o_status = ST_OVERFLOW;
                            end
                            else
                            begin
                                cell_op    = (req.req_type == REQ_PUSH_FRONT) ?
                                             CELL_TAKE_LOWER : CELL_WRITE;
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        REQ_POP_FRONT, REQ_POP_BACK:
                        begin
                            if (count_reg == '0)
                            begin
                                load_out = 1'b1;
                                o_status = ST_UNDERFLOW;
                            end
                            else if (req.req_type == REQ_POP_FRONT ||
                                     count_reg == CNT_W'(1))
                            begin
                                load_out   = 1'b1;
                                o_data     = cell_q[0];
                                cell_op    = CELL_TAKE_UPPER;
                                count_next = count_m1;
                            end
                            else
                            begin
                                state_next = S_ROT;
                                step_next  = '0;
                            end
                        end
                        REQ_LIST:
                        begin
                            if (count_reg == '0)
                            begin
                                load_out = 1'b1;
                                o_status = ST_EMPTY;
                            end
                            else
                            begin
                                state_next = S_LIST;
                                step_next  = '0;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_ROT:
            begin
                cell_op      = CELL_ROTATE;
                use_back_sel = 1'b1;
                if (step_reg == count_m2[IDX_W-1:0])
                begin
                    state_next = S_POPB;
                end
                else
                begin
                    step_next = step_reg + IDX_W'(1);
                end
            end
            S_POPB:
            begin
                if (out_free)
                begin
                    load_out   = 1'b1;
                    o_data     = cell_q[0];
                    cell_op    = CELL_TAKE_UPPER;
                    count_next = count_m1;
                    state_next = S_IDLE;
                end
            end
            S_LIST:
            begin
                if (!emit || out_free)
                begin
                    cell_op      = CELL_ROTATE;
                    use_back_sel = 1'b1;
                    load_out     = emit;
                    o_data       = cell_q[0];
                    o_last       = (step_reg == count_m1[IDX_W-1:0]) ||
                                   (32'(step_reg) == MAX_RESULTS - 1);
                    if (step_reg == count_m1[IDX_W-1:0])
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        step_next = step_reg + IDX_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            count_reg <= count_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_status_reg <= o_status;
            out_data_reg   <= o_data;
            out_last_reg   <= o_last;
        end
    end

    assign rsp.valid  = out_valid_reg;
    assign rsp.status = out_status_reg;
    assign rsp.data   = out_data_reg;
    assign rsp.last   = out_last_reg;

    // Cell chain: cell 0 is the front of the queue
    for (genvar g = 0; g < DEPTH; g++)
    begin : g_cell
        cell_ctrl_t               ctrl;
        logic signed [DATA_W-1:0] lower;
        logic signed [DATA_W-1:0] upper;

        assign ctrl.op  = cell_op;
        assign ctrl.sel = (sel_idx == IDX_W'(g));

        if (g == 0)
        begin : g_first
            assign lower = req.value;
        end
        else
        begin : g_inner_lo
            assign lower = cell_q[g-1];
        end

        if (g == DEPTH - 1)
        begin : g_last
            assign upper = cell_q[g];
        end
        else
        begin : g_inner_hi
            assign upper = cell_q[g+1];
        end

        deq_cell u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .lower      (lower),
            .upper      (upper),
            .head       (cell_q[0]),
            .push_value (req.value),
            .entry      (cell_q[g])
        );
    end

endmodule

@@ dv/tb_double_ended_queue.sv @@
`timescale 1ns / 1ps
// Testbench for double_ended_queue: directed and random requests checked against a
// deque predictor, with idle, stall and long hold-off phases.
// Depends on deq_pkg, deq_req_if, deq_rsp_if and double_ended_queue.
module tb_double_ended_queue;
    import deq_pkg::*;

    localparam int QUEUE_DEPTH = 16;
    localparam int HOLD_CYCLES = 400;
    localparam int STALL_LIMIT = 3000;
    localparam int SETTLE_CYCLES = 2 * QUEUE_DEPTH + 8;
    localparam logic [2:0] REQ_UNUSED_FIRST = 3'd5;
    localparam logic [2:0] REQ_UNUSED_LAST  = 3'd7;
    localparam int IDLE_PLAN[4]  = '{0, 69, 0, 7};
    localparam int STALL_PLAN[4] = '{0, 0, 69, 7};

    typedef struct packed {
        logic [1:0]               status;
        logic signed [DATA_W-1:0] data;
        logic                     last;
    } deq_result_t;

    typedef enum {MIX_FILL, MIX_BALANCED, MIX_DRAIN} req_mix_t;

    class deque_scoreboard;
        logic signed [DATA_W-1:0] slots [QUEUE_DEPTH];
        int                       front_slot;
        int                       fill_count;
        deq_result_t              awaited_results [$];
        int                       errors;

        function new();
            front_slot = 0;
            fill_count = 0;
            errors     = 0;
        endfunction

        function void add_result(logic [1:0] st, logic signed [DATA_W-1:0] d, logic l);
            deq_result_t r;
            r.status = st;
            r.data   = d;
            r.last   = l;
            awaited_results.push_back(r);
        endfunction

        function int pending();
            return awaited_results.size();
        endfunction

        function void note_request(logic [2:0] kind, logic signed [DATA_W-1:0] v);
            logic signed [DATA_W-1:0] popped;
            int                       n;
            case (kind)
                REQ_PUSH_FRONT, REQ_PUSH_BACK:
                begin
                    if (fill_count >= QUEUE_DEPTH)
                    begin
                        add_result(ST_OVERFLOW, '0, 1'b1);
                    end
                    else
                    begin
                        if (kind == REQ_PUSH_FRONT)
                        begin
                            front_slot = (front_slot + QUEUE_DEPTH - 1) % QUEUE_DEPTH;
                            slots[front_slot] = v;
                        end
                        else
                        begin
                            slots[(front_slot + fill_count) % QUEUE_DEPTH] = v;
                        end
                        fill_count++;
                        add_result(ST_OK, '0, 1'b1);
                    end
                end
                REQ_POP_FRONT, REQ_POP_BACK:
                begin
                    if (fill_count == 0)
                    begin
                        add_result(ST_UNDERFLOW, '0, 1'b1);
                    end
                    else
                    begin
                        if (kind == REQ_POP_FRONT)
                        begin
                            popped = slots[front_slot];
                            front_slot = (front_slot + 1) % QUEUE_DEPTH;
                        end
                        else
                        begin
                            popped = slots[(front_slot + fill_count - 1) % QUEUE_DEPTH];
                        end
                        fill_count--;
                        add_result(ST_OK, popped, 1'b1);
                    end
                end
                REQ_LIST:
                begin
                    if (fill_count == 0)
                    begin
                        add_result(ST_EMPTY, '0, 1'b1);
                    end
                    else
                    begin
                        n = (fill_count > MAX_RESULTS) ? MAX_RESULTS : fill_count;
                        for (int i = 0; i < n; i++)
                        begin
                            add_result(ST_OK, slots[(front_slot + i) % QUEUE_DEPTH],
                                       (i + 1 == n));
                        end
                    end
                end
                default:
                begin
                end
            endcase
        endfunction

        function void check_result(logic [1:0] st, logic signed [DATA_W-1:0] d, logic l);
            deq_result_t want;
            bit          bad;
            if (awaited_results.size() == 0)
            begin
                $display("%0t: unexpected result: status %0d data %0d last %0d",
                         $time, st, d, l);
                errors++;
                return;
            end
            want = awaited_results.pop_front();
            bad  = 1'b0;
            if (st !== want.status)
            begin
                $display("%0t: status mismatch: expected %0d, actual %0d",
                         $time, want.status, st);
                bad = 1'b1;
            end
            if (d !== want.data)
            begin
                $display("%0t: data mismatch: expected %0d, actual %0d",
                         $time, want.data, d);
                bad = 1'b1;
            end
            if (l !== want.last)
            begin
                $display("%0t: last mismatch: expected %0d, actual %0d",
                         $time, want.last, l);
                bad = 1'b1;
            end
            if (bad)
            begin
                errors++;
            end
        endfunction
    endclass

    logic            clk = 1'b0;
    logic            rst_n;
    logic            req_fire = 1'b0;
    int              req_idle_pct = 0;
    int              rsp_stall_pct = 0;
    int              hold_requests = 0;
    int              quiet_cycles = 0;
    deque_scoreboard sb;

    deq_req_if req_ch ();
    deq_rsp_if rsp_ch ();

    double_ended_queue #(.DEPTH(QUEUE_DEPTH)) uut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    always #6 clk = ~clk;

    // req_fire: a request transfer took place at the last rising edge
    always @(posedge clk)
    begin
        req_fire <= ((req_ch.valid && req_ch.ready) === 1'b1);
        if ((req_ch.valid && req_ch.ready) === 1'b1)
        begin
            sb.note_request(req_ch.req_type, req_ch.value);
        end
        if ((rsp_ch.valid && rsp_ch.ready) === 1'b1)
        begin
            sb.check_result(rsp_ch.status, rsp_ch.data, rsp_ch.last);
        end
    end

    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) === 1'b1 || (rsp_ch.valid && rsp_ch.ready) === 1'b1)
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
            $display("** double_ended_queue: FAILED **");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        int hold_left;
        int holds_done;
        hold_left  = 0;
        holds_done = 0;
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_requests != holds_done)
            begin
                holds_done = hold_requests;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else
            begin
                rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
            end
        end
    end

    function automatic logic signed [DATA_W-1:0] pick_value();
        case ($urandom_range(15))
            0:       return {1'b1, {(DATA_W-1){1'b0}}};
            1:       return {1'b0, {(DATA_W-1){1'b1}}};
            2:       return '0;
            3:       return '1;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [2:0] pick_kind(req_mix_t mix);
        int roll;
        int push_pct;
        int pop_pct;
        roll = $urandom_range(99);
        case (mix)
            MIX_FILL:
            begin
                push_pct = 80;
                pop_pct  = 10;
            end
            MIX_DRAIN:
            begin
                push_pct = 10;
                pop_pct  = 80;
            end
            default:
            begin
                push_pct = 40;
                pop_pct  = 40;
            end
        endcase
        if (roll < 4)
            return REQ_UNUSED_FIRST + 3'($urandom_range(2));
        else if (roll < 4 + push_pct)
            return $urandom_range(1) ? REQ_PUSH_BACK : REQ_PUSH_FRONT;
        else if (roll < 4 + push_pct + pop_pct)
            return $urandom_range(1) ? REQ_POP_BACK : REQ_POP_FRONT;
        else
            return REQ_LIST;
    endfunction

    // entered and left at a falling edge
    task automatic send_request(input logic [2:0] kind, input logic signed [DATA_W-1:0] v);
        while ($urandom_range(99) < req_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.req_type <= kind;
        req_ch.value    <= v;
        do
            @(negedge clk);
        while (req_fire !== 1'b1);
    endtask

    task automatic run_items(input int count, input req_mix_t mix);
        logic [2:0] kind;
        int         done;
        done = 0;
        while (done < count)
        begin
            kind = pick_kind(mix);
            send_request(kind, pick_value());
            if (kind <= REQ_LIST)
                done++;
        end
    endtask

    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        @(negedge clk);
        while (sb.pending() != 0)
            @(negedge clk);
    endtask

    initial
    begin
        sb = new();
        rst_n           = 1'b0;
        req_ch.valid    = 1'b0;
        req_ch.req_type = REQ_LIST;
        req_ch.value    = '0;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;

        // empty queue, sole entry, unused codes, extremes
        send_request(REQ_LIST, '0);
        send_request(REQ_POP_FRONT, '0);
        send_request(REQ_POP_BACK, '0);
        send_request(REQ_PUSH_FRONT, {1'b1, {(DATA_W-1){1'b0}}});
        send_request(REQ_POP_BACK, '0);
        send_request(REQ_PUSH_BACK, {1'b0, {(DATA_W-1){1'b1}}});
        send_request(REQ_POP_FRONT, '0);
        for (int c = REQ_UNUSED_FIRST; c <= REQ_UNUSED_LAST; c++)
            send_request(3'(c), pick_value());
        send_request(REQ_PUSH_FRONT, '1);
        send_request(REQ_PUSH_BACK, '0);
        send_request(REQ_PUSH_FRONT, 32'h5555_5555);
        send_request(REQ_PUSH_BACK, 32'hAAAA_AAAA);
        send_request(REQ_LIST, '0);
        send_request(REQ_POP_BACK, '0);
        send_request(REQ_POP_FRONT, '0);
        send_request(REQ_LIST, '0);
        wait_drained();

        for (int p = 0; p < 4; p++)
        begin
            req_idle_pct  = IDLE_PLAN[p];
            rsp_stall_pct = STALL_PLAN[p];
            if (p == 0)
            begin
                // long result hold-off: fill up until requests back up
                run_items(20, MIX_FILL);
                hold_requests++;
                run_items(40, MIX_FILL);
                wait_drained();
            end
            for (int s = 0; s < 6; s++)
                run_items(20, req_mix_t'(s % 3));
            wait_drained();
        end

        repeat (SETTLE_CYCLES) @(negedge clk);
        if (sb.errors == 0)
            $display("** double_ended_queue: PASSED **");
        else
            $display("** double_ended_queue: FAILED **");
        $finish;
    end

endmodule
